### rtl/tie_pkg.sv
// ----------------------------------------------------------------------------
// tie_pkg: shared types and constants of the trigonometric interpolator
// Widths, state codes, unit handshakes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tie_pkg;

    // default storage depth
    localparam int MAX_POINTS_DEF = 64;

    // configuration register widths
    localparam int NPT_W = 7;
    localparam int HSTEP_W = 31;

    // wide datapath widths (n can never exceed 127)
    localparam int DIV_W = 42;
    localparam int ACC_W = 41;
    localparam int RE_W = 44;
    localparam int PH_W = 38;
    localparam int CW = 34;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int SHP_W = PROD_W - 30;

    // CORDIC
    localparam int CORDIC_STEPS = 28;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // item operation codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_NUM_POINTS = 2'd0;
    localparam logic [1:0] REG_X_ORIGIN = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEN,
        S_PT_DIV,
        S_PT_DW,
        S_PT_CW,
        S_MOD,
        S_MOD_W,
        S_VINIT,
        S_J_START,
        S_RD,
        S_MC,
        S_MS,
        S_MA,
        S_DR,
        S_DRW,
        S_DI,
        S_DIW,
        S_PH,
        S_PHW,
        S_PCW,
        S_O1,
        S_O2,
        S_O3,
        S_O4,
        S_O5,
        S_DONE
    } state_t;

    // divider command: frac_mode runs 32 quotient bits, otherwise DIV_W
    typedef struct packed {
        logic start;
        logic frac_mode;
    } div_cmd_t;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // arctangent of 2^-i in binary angle (2^32 is one turn)
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0: a = 32'h20000000;
            5'd1: a = 32'h12E4051E;
            5'd2: a = 32'h09FB385B;
            5'd3: a = 32'h051111D4;
            5'd4: a = 32'h028B0D43;
            5'd5: a = 32'h0145D7E1;
            5'd6: a = 32'h00A2F61E;
            5'd7: a = 32'h00517C55;
            5'd8: a = 32'h0028BE53;
            5'd9: a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

### rtl/trig_interpolation_eval.sv
// ----------------------------------------------------------------------------
// trig_interpolation_eval: trigonometric interpolant of stored samples
// Store items fill the sample memory; evaluate items run the DFT and the
// interpolant sum on one shared multiplier, divider and CORDIC.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  operation, sample_index, sample_value, query_x
//  out      out_valid/ out_stall real_part, imag_part, saturated
//  cfg      cfg_we               cfg_index, cfg_data
//
//  a store item writes the sample memory while the unit stays idle; the
//  run time of an evaluate is set by the shared multiplier (used for each of
//  the n^2 sample terms) and by the bit-serial divider and CORDIC (used for
//  each phase table entry and each coefficient)
//  in_stall is high while an evaluate runs; the result waits in the output
//  register, and a further evaluate can run meanwhile
//  reset clears control state only; the sample memory is undefined
// ----------------------------------------------------------------------------
module trig_interpolation_eval import tie_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [5:0]         sample_index,
    input  logic signed [31:0] sample_value,
    input  logic signed [31:0] query_x,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] real_part,
    output logic signed [31:0] imag_part,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NLIM = (MAX_POINTS < 127) ? MAX_POINTS : 127;
    localparam logic [NPT_W-1:0] NLIM7 = NPT_W'(NLIM);

    // configuration
    logic [NPT_W-1:0]   num_points_reg;
    logic [31:0]        x_origin_reg;
    logic [HSTEP_W-1:0] step_size_reg;

    // sequencer state
    state_t              state_reg, state_next;
    logic [NPT_W-1:0]    n_reg, n_next;
    logic [HSTEP_W-1:0]  h_reg, h_next;
    logic [PH_W-1:0]     den_reg, den_next;
    logic signed [32:0]  dx_reg, dx_next;
    logic [PH_W-1:0]     r_reg, r_next;
    logic [PH_W-1:0]     v_reg, v_next;
    logic [NPT_W-1:0]    cnt_reg, cnt_next;
    logic [NPT_W-1:0]    jcnt_reg, jcnt_next;
    logic [NPT_W-1:0]    p_reg, p_next;
    logic [NPT_W-1:0]    m_reg, m_next;
    logic signed [ACC_W-1:0] ar_reg, ar_next;
    logic signed [ACC_W-1:0] ai_reg, ai_next;
    logic signed [RE_W-1:0]  re_reg, re_next;
    logic signed [RE_W-1:0]  im_reg, im_next;
    logic signed [SHP_W-1:0] t_reg, t_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] real_reg, real_next;
    logic signed [31:0] imag_reg, imag_next;
    logic               sat_reg, sat_next;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SHP_W-1:0]   prod_sh;

    // memories
    logic [31:0] smp_mem [MAX_POINTS];
    logic [63:0] cs_mem [MAX_POINTS];
    logic [31:0] smp_rd_reg;
    logic [63:0] cs_rd_reg;
    logic        smp_we;
    logic        cs_we;

    // shared units
    div_cmd_t         div_cmd;
    unit_stat_t       div_stat;
    logic [DIV_W-1:0] div_rem_init;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_q;
    logic [DIV_W-1:0] div_r;
    logic             cor_start;
    logic [31:0]      cor_turn;
    logic signed [31:0] cor_cos;
    logic signed [31:0] cor_sin;
    unit_stat_t       cor_stat;

    // helpers
    logic [NPT_W-1:0]    n_clamp;
    logic [NPT_W-1:0]    half;
    logic [NPT_W:0]      p_sum;
    logic [PH_W:0]       v_dn;
    logic [PH_W:0]       v_up;
    logic [32:0]         dx_mag;
    logic [ACC_W-1:0]    ar_mag;
    logic [ACC_W-1:0]    ai_mag;
    logic [ACC_W-1:0]    q_acc;
    logic [PH_W-1:0]     rem_ph;
    logic                in_acc;

    tie_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    tie_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .turn    (cor_turn),
        .cos_out (cor_cos),
        .sin_out (cor_sin),
        .stat    (cor_stat)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NPT_W'(1);
            x_origin_reg <= '0;
            step_size_reg <= HSTEP_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_POINTS: num_points_reg <= cfg_data[NPT_W-1:0];
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_STEP_SIZE: step_size_reg <= cfg_data[HSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    // common terms
    always_comb
    begin
        in_acc = in_valid && !in_stall;
        n_clamp = (num_points_reg == '0) ? NPT_W'(1) : num_points_reg;
        if (n_clamp > NLIM7)
        begin
            n_clamp = NLIM7;
        end
        half = (n_reg - NPT_W'(1)) >> 1;
        p_sum = {1'b0, p_reg} + {1'b0, m_reg};
        v_dn = {1'b0, v_reg} + {1'b0, den_reg} - {1'b0, r_reg};
        v_up = {1'b0, v_reg} + {1'b0, r_reg};
        dx_mag = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ar_mag = ar_reg[ACC_W-1] ? ACC_W'(-ar_reg) : ACC_W'(ar_reg);
        ai_mag = ai_reg[ACC_W-1] ? ACC_W'(-ai_reg) : ACC_W'(ai_reg);
        q_acc = div_q[ACC_W-1:0];
        rem_ph = div_r[PH_W-1:0];
        prod_sh = prod_reg[PROD_W-1:30];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        h_next = h_reg;
        den_next = den_reg;
        dx_next = dx_reg;
        r_next = r_reg;
        v_next = v_reg;
        cnt_next = cnt_reg;
        jcnt_next = jcnt_reg;
        p_next = p_reg;
        m_next = m_reg;
        ar_next = ar_reg;
        ai_next = ai_reg;
        re_next = re_reg;
        im_next = im_reg;
        t_next = t_reg;
        out_valid_next = out_valid_reg && out_stall;
        real_next = real_reg;
        imag_next = imag_reg;
        sat_next = sat_reg;
        div_cmd = '{start: 1'b0, frac_mode: 1'b0};
        div_rem_init = '0;
        div_dividend = '0;
        div_divisor = DIV_W'(n_reg);
        cor_start = 1'b0;
        cor_turn = div_q[31:0];
        mul_a = MUL_A_W'($signed(smp_rd_reg));
        mul_b = $signed(cs_rd_reg[63:32]);
        smp_we = 1'b0;
        cs_we = 1'b0;
        in_stall = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (operation == OP_EVAL)
                    begin
                        n_next = n_clamp;
                        h_next = (step_size_reg == '0) ? HSTEP_W'(1) : step_size_reg;
                        dx_next = 33'(query_x) - 33'($signed(x_origin_reg));
                        cnt_next = '0;
                        re_next = '0;
                        im_next = '0;
                        state_next = S_DEN;
                    end
                    else if (32'(sample_index) < 32'(MAX_POINTS))
                    begin
                        smp_we = 1'b1;
                    end
                end
            end
            S_DEN:
            begin
                den_next = PH_W'(n_reg) * PH_W'(h_reg);
                state_next = S_PT_DIV;
            end
            // phase table: cos and sin of 2 pi p / n
            S_PT_DIV:
            begin
                div_cmd = '{start: 1'b1, frac_mode: 1'b1};
                div_rem_init = DIV_W'(cnt_reg);
                state_next = S_PT_DW;
            end
            S_PT_DW:
            begin
                if (div_stat.done)
                begin
                    cor_start = 1'b1;
                    state_next = S_PT_CW;
                end
            end
            S_PT_CW:
            begin
                if (cor_stat.done)
                begin
                    cs_we = 1'b1;
                    cnt_next = cnt_reg + NPT_W'(1);
                    state_next = (cnt_reg == n_reg - NPT_W'(1)) ? S_MOD : S_PT_DIV;
                end
            end
            // offset per j: dx mod (n h)
            S_MOD:
            begin
                div_cmd = '{start: 1'b1, frac_mode: 1'b0};
                div_dividend = DIV_W'(dx_mag);
                div_divisor = DIV_W'(den_reg);
                state_next = S_MOD_W;
            end
            S_MOD_W:
            begin
                if (div_stat.done)
                begin
                    if (dx_reg[32] && rem_ph != '0)
                    begin
                        r_next = den_reg - rem_ph;
                    end
                    else
                    begin
                        r_next = rem_ph;
                    end
                    v_next = '0;
                    cnt_next = '0;
                    state_next = S_VINIT;
                end
            end
            // walk back to the lowest j
            S_VINIT:
            begin
                if (cnt_reg == half)
                begin
                    m_next = half;
                    jcnt_next = '0;
                    state_next = S_J_START;
                end
                else
                begin
                    cnt_next = cnt_reg + NPT_W'(1);
                    v_next = (v_reg < r_reg) ? v_dn[PH_W-1:0] : v_reg - r_reg;
                end
            end
            S_J_START:
            begin
                ar_next = '0;
                ai_next = '0;
                cnt_next = '0;
                p_next = '0;
                state_next = S_RD;
            end
            // coefficient sum over the samples
            S_RD:
            begin
                state_next = S_MC;
            end
            S_MC:
            begin
                state_next = S_MS;
            end
            S_MS:
            begin
                ar_next = ar_reg + ACC_W'(prod_sh);
                mul_b = $signed(cs_rd_reg[31:0]);
                state_next = S_MA;
            end
            S_MA:
            begin
                ai_next = ai_reg + ACC_W'(prod_sh);
                cnt_next = cnt_reg + NPT_W'(1);
                if (p_sum >= {1'b0, n_reg})
                begin
                    p_next = NPT_W'(p_sum - {1'b0, n_reg});
                end
                else
                begin
                    p_next = p_sum[NPT_W-1:0];
                end
                state_next = (cnt_reg == n_reg - NPT_W'(1)) ? S_DR : S_RD;
            end
            // scale by 1/n, toward zero
            S_DR:
            begin
                div_cmd = '{start: 1'b1, frac_mode: 1'b0};
                div_dividend = DIV_W'(ar_mag);
                state_next = S_DRW;
            end
            S_DRW:
            begin
                if (div_stat.done)
                begin
                    ar_next = ar_reg[ACC_W-1] ? -$signed(q_acc) : $signed(q_acc);
                    state_next = S_DI;
                end
            end
            S_DI:
            begin
                div_cmd = '{start: 1'b1, frac_mode: 1'b0};
                div_dividend = DIV_W'(ai_mag);
                state_next = S_DIW;
            end
            S_DIW:
            begin
                if (div_stat.done)
                begin
                    ai_next = ai_reg[ACC_W-1] ? -$signed(q_acc) : $signed(q_acc);
                    state_next = S_PH;
                end
            end
            // evaluation phase
            S_PH:
            begin
                div_cmd = '{start: 1'b1, frac_mode: 1'b1};
                div_rem_init = DIV_W'(v_reg);
                div_divisor = DIV_W'(den_reg);
                state_next = S_PHW;
            end
            S_PHW:
            begin
                if (div_stat.done)
                begin
                    cor_start = 1'b1;
                    state_next = S_PCW;
                end
            end
            S_PCW:
            begin
                if (cor_stat.done)
                begin
                    state_next = S_O1;
                end
            end
            // complex multiply-accumulate
            S_O1:
            begin
                mul_a = ar_reg[MUL_A_W-1:0];
                mul_b = cor_cos;
                state_next = S_O2;
            end
            S_O2:
            begin
                t_next = prod_sh;
                mul_a = ai_reg[MUL_A_W-1:0];
                mul_b = cor_sin;
                state_next = S_O3;
            end
            S_O3:
            begin
                re_next = re_reg + RE_W'(t_reg) - RE_W'(prod_sh);
                mul_a = ar_reg[MUL_A_W-1:0];
                mul_b = cor_sin;
                state_next = S_O4;
            end
            S_O4:
            begin
                t_next = prod_sh;
                mul_a = ai_reg[MUL_A_W-1:0];
                mul_b = cor_cos;
                state_next = S_O5;
            end
            S_O5:
            begin
                im_next = im_reg + RE_W'(t_reg) + RE_W'(prod_sh);
                if (jcnt_reg == n_reg - NPT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    jcnt_next = jcnt_reg + NPT_W'(1);
                    v_next = (v_up >= {1'b0, den_reg}) ?
                             PH_W'(v_up - {1'b0, den_reg}) : v_up[PH_W-1:0];
                    m_next = (m_reg == '0) ? n_reg - NPT_W'(1) : m_reg - NPT_W'(1);
                    state_next = S_J_START;
                end
            end
            // saturate into the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sat_next = 1'b0;
                    if (re_reg > RE_W'(32'sh7FFF_FFFF))
                    begin
                        real_next = 32'sh7FFF_FFFF;
                        sat_next = 1'b1;
                    end
                    else if (re_reg < -RE_W'(33'sh0_8000_0000))
                    begin
                        real_next = 32'sh8000_0000;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        real_next = re_reg[31:0];
                    end
                    if (im_reg > RE_W'(32'sh7FFF_FFFF))
                    begin
                        imag_next = 32'sh7FFF_FFFF;
                        sat_next = 1'b1;
                    end
                    else if (im_reg < -RE_W'(33'sh0_8000_0000))
                    begin
                        imag_next = 32'sh8000_0000;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        imag_next = im_reg[31:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg <= NPT_W'(1);
            cnt_reg <= '0;
            jcnt_reg <= '0;
            p_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg <= n_next;
            cnt_reg <= cnt_next;
            jcnt_reg <= jcnt_next;
            p_reg <= p_next;
            m_reg <= m_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        den_reg <= den_next;
        dx_reg <= dx_next;
        r_reg <= r_next;
        v_reg <= v_next;
        ar_reg <= ar_next;
        ai_reg <= ai_next;
        re_reg <= re_next;
        im_reg <= im_next;
        t_reg <= t_next;
        real_reg <= real_next;
        imag_reg <= imag_next;
        sat_reg <= sat_next;
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            smp_mem[IDX_W'(sample_index)] <= sample_value;
        end
        smp_rd_reg <= smp_mem[IDX_W'(cnt_reg)];
    end

    // phase table memory
    always_ff @(posedge clk)
    begin
        if (cs_we)
        begin
            cs_mem[IDX_W'(cnt_reg)] <= {cor_cos, cor_sin};
        end
        cs_rd_reg <= cs_mem[IDX_W'(p_reg)];
    end

    assign out_valid = out_valid_reg;
    assign real_part = real_reg;
    assign imag_part = imag_reg;
    assign saturated = sat_reg;

    // shared units are only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_cor_free: assert property (@(posedge clk) disable iff (!rst_n)
        cor_start |-> !cor_stat.busy)
        else $error("cordic started while busy");

    // a result appears only at the end of an evaluation
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    // an accepted evaluate starts the sequence
    a_eval_go: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == OP_EVAL) |=> state_reg == S_DEN)
        else $error("evaluate item not started");

endmodule

### rtl/tie_divider.sv
// ----------------------------------------------------------------------------
// tie_divider: shared restoring divider
// One quotient bit per cycle; gives quotient and remainder of
// (rem_init : dividend) / divisor.
// ----------------------------------------------------------------------------
module tie_divider import tie_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  div_cmd_t         cmd,
    input  logic [DIV_W-1:0] rem_init,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder,
    output unit_stat_t       stat
);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W-1:0] q_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIV_W-1]};
        diff = shifted - {1'b0, dsr_reg};
        ge = (shifted >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= cmd.frac_mode ? 6'd32 : 6'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            q_reg <= {q_reg[DIV_W-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign remainder = rem_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

### rtl/tie_cordic.sv
// ----------------------------------------------------------------------------
// tie_cordic: iterative rotation-mode CORDIC
// Cosine and sine, in Q2.30, of a binary angle (2^32 is one turn), one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tie_cordic import tie_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        turn,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out,
    output unit_stat_t         stat
);

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic [1:0]           quad_reg;
    logic [4:0]           i_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [31:0]   cos_reg;
    logic signed [31:0]   sin_reg;

    logic [1:0]           quad;
    logic [31:0]          r;
    logic [31:0]          rot;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic                 last;

    // quadrant reduction and step terms
    always_comb
    begin
        rot = turn + 32'h2000_0000;
        quad = rot[31:30];
        r = turn - {quad, 30'b0};
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = $signed({2'b00, atan_turn(i_reg)});
        last = (i_reg == 5'(CORDIC_STEPS - 1));
    end

    // quadrant restore
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cx = x_reg;
                cy = y_reg;
            end
            2'd1:
            begin
                cx = -y_reg;
                cy = x_reg;
            end
            2'd2:
            begin
                cx = -x_reg;
                cy = -y_reg;
            end
            default:
            begin
                cx = y_reg;
                cy = -x_reg;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= CW'($signed(r));
            quad_reg <= quad;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        else
        begin
            cos_reg <= cx[31:0];
            sin_reg <= cy[31:0];
        end
    end

    assign cos_out = done_reg ? cx[31:0] : cos_reg;
    assign sin_out = done_reg ? cy[31:0] : sin_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule
